/* hw/rtl/sha256_message_digest_assert.svh */
// Assertion macros for the checker file of the SHA-256 hasher.
// Each macro expects a signal named clk and an active-low rst_n in scope.
`ifndef SHA256_MESSAGE_DIGEST_ASSERT_SVH
`define SHA256_MESSAGE_DIGEST_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define SHA_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("sha256 check failed");

// Next-cycle implication, quiet during reset.
`define SHA_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sha256 check failed");

`endif

/* hw/rtl/sha_pkg.sv */
// Shared types, constants and round-constant table for the SHA-256 hasher.
// No dependencies.
package sha_pkg;

  localparam int WordW    = 32;
  localparam int BufWords = 16;
  localparam int BufAw    = 4;

  typedef logic [7:0][WordW-1:0] chain_t;

  // Control from the sequencer to the compression core.
  typedef struct packed {
    logic ld_shift;  // shift one schedule word in from the buffer RAM
    logic start;     // working variables take the chaining words
    logic rnd;       // one compression round
    logic fold;      // chaining words += working variables
    logic init;      // chaining words back to the initial hash
  } core_ctrl_t;

  localparam logic [1:0] REQ_ABSORB     = 2'd0;
  localparam logic [1:0] REQ_ABSORB_FIN = 2'd1;
  localparam logic [1:0] REQ_FINISH     = 2'd2;

  localparam chain_t IV = {32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
                           32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

/* hw/rtl/sha_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sha_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/sha_core.sv */
// SHA-256 compression core: schedule shift line, working variables, chaining words.
// Depends on sha_pkg.
module sha_core (
  input  logic                clk,
  input  logic                rst_n,
  input  sha_pkg::core_ctrl_t ctrl,
  input  logic [31:0]         ld_data,
  input  logic [5:0]          rnd_idx,
  output sha_pkg::chain_t     chain
);
  import sha_pkg::*;

  logic [31:0] w_r [BufWords];
  logic [31:0] v_r [8];
  chain_t      chain_r;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    logic [63:0] t;
    t = {x, x} >> n;
    return t[31:0];
  endfunction

  logic [31:0] big0, big1, choose, major, t1, t2, s0, s1, w_new;

  always_comb begin
    big1   = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    choose = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1     = v_r[7] + big1 + choose + round_k(rnd_idx) + w_r[0];
    big0   = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    major  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2     = big0 + major;
    s0     = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1     = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new  = s1 + w_r[9] + s0 + w_r[0];
  end

  // schedule: w_r[0] is W[t]; the line shifts down one word per round
  always_ff @(posedge clk) begin
    if (ctrl.ld_shift || ctrl.rnd) begin
      for (int i = 0; i < BufWords - 1; i++) w_r[i] <= w_r[i+1];
      w_r[BufWords-1] <= ctrl.ld_shift ? ld_data : w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      for (int i = 0; i < 8; i++) v_r[i] <= chain_r[i];
    end else if (ctrl.rnd) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.init) begin
      chain_r <= IV;
    end else if (ctrl.fold) begin
      for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + v_r[i];
    end
  end

  assign chain = chain_r;
endmodule

/* hw/rtl/sha256_message_digest.sv */
// Top level of the streaming SHA-256 hasher: sequencer, block buffer RAM, core.
// Depends on sha_pkg, sha_ram and sha_core.
//
// Input items are taken one per cycle while idle, except that the item completing a
// 64-byte block makes the hasher busy (load steps that bring the 16 buffer words
// into the schedule line behind the RAM's registered read, the working variables
// starting in the last of them, 64 rounds at one per cycle, one fold) before
// in_tready returns. A finish adds a setup step, writes the padding words to the
// buffer RAM one per cycle (up to 16), runs one or two compressions, then emits
// 32 output items, one per cycle while out_tready is high. Input is not taken
// while padding, compressing or emitting the digest; the buffer RAM's single
// port pair sets the one-word-per-cycle load and pad pace.
module sha256_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] digest_byte, [12:8] byte_index, [15:13] zero
  output logic        out_tlast   // last_byte
);
  import sha_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIN   = 3'd1;
  localparam logic [2:0] S_PAD   = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_FOLD  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [63:0] total_r, total_nxt;
  logic [23:0] gath_r, gath_nxt;
  logic        fin_r, fin_nxt;        // finish pending after this compression
  logic        pad_r, pad_nxt;        // compressing a padded block
  logic        len_here_r, len_here_nxt;
  logic        first_r, first_nxt;    // next pad word carries the 0x80
  logic [3:0]  wptr_r, wptr_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [4:0]  oidx_r, oidx_nxt;

  logic             we;
  logic [BufAw-1:0] waddr, raddr;
  logic [31:0]      wdata, rdata, pad_word;
  core_ctrl_t       ctrl;
  chain_t           chain;
  logic             in_acc, out_acc;
  logic [6:0]       fill_inc;
  logic [31:0]      dword;
  logic [7:0]       dbyte;

  // RAM writes happen only in idle and pad; reads only in load, so the
  // sequencer itself keeps the two apart.
  sha_ram #(.Width(WordW), .Depth(BufWords)) u_buf (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  sha_core u_core (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .ld_data(rdata), .rnd_idx(rnd_r), .chain(chain)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;
  assign fill_inc   = {1'b0, fill_r} + 7'd1;

  always_comb begin
    case (fill_r[1:0])
      2'd0:    pad_word = 32'h80000000;
      2'd1:    pad_word = {gath_r[7:0], 24'h800000};
      2'd2:    pad_word = {gath_r[15:0], 16'h8000};
      default: pad_word = {gath_r, 8'h80};
    endcase
  end

  always_comb begin
    dword = chain[oidx_r[4:2]];
    case (oidx_r[1:0])
      2'd0:    dbyte = dword[31:24];
      2'd1:    dbyte = dword[23:16];
      2'd2:    dbyte = dword[15:8];
      default: dbyte = dword[7:0];
    endcase
  end
  assign out_tdata = {3'b000, oidx_r, dbyte};
  assign out_tlast = (oidx_r == 5'd31);

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    bits_nxt     = bits_r;
    total_nxt    = total_r;
    gath_nxt     = gath_r;
    fin_nxt      = fin_r;
    pad_nxt      = pad_r;
    len_here_nxt = len_here_r;
    first_nxt    = first_r;
    wptr_nxt     = wptr_r;
    cnt_nxt      = cnt_r;
    rnd_nxt      = rnd_r;
    oidx_nxt     = oidx_r;
    we           = 1'b0;
    waddr        = wptr_r;
    wdata        = 32'h0;
    raddr        = cnt_r[3:0];
    ctrl         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == REQ_ABSORB || in_tuser == REQ_ABSORB_FIN) begin
            gath_nxt = {gath_r[15:0], in_tdata};
            fill_nxt = fill_inc[5:0];
            we       = (fill_r[1:0] == 2'd3);
            waddr    = fill_r[5:2];
            wdata    = {gath_r, in_tdata};
            fin_nxt  = (in_tuser == REQ_ABSORB_FIN);
            if (fill_inc[6]) begin
              cnt_nxt   = '0;
              state_nxt = S_LOAD;
            end else if (in_tuser == REQ_ABSORB_FIN) begin
              state_nxt = S_FIN;
            end
          end else if (in_tuser == REQ_FINISH) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        total_nxt    = bits_r + {55'd0, fill_r, 3'b000};
        len_here_nxt = (fill_r < 6'd56);
        wptr_nxt     = fill_r[5:2];
        first_nxt    = 1'b1;
        pad_nxt      = 1'b1;
        fin_nxt      = 1'b0;
        state_nxt    = S_PAD;
      end
      S_PAD: begin
        we = 1'b1;
        if (first_r) wdata = pad_word;
        else if (len_here_r && wptr_r == 4'd14) wdata = total_r[63:32];
        else if (len_here_r && wptr_r == 4'd15) wdata = total_r[31:0];
        first_nxt = 1'b0;
        wptr_nxt  = wptr_r + 4'd1;
        if (wptr_r == 4'd15) begin
          cnt_nxt   = '0;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        ctrl.ld_shift = (cnt_r != 5'd0);
        cnt_nxt       = cnt_r + 5'd1;
        if (cnt_r == 5'd16) begin
          ctrl.start = 1'b1;
          rnd_nxt    = '0;
          state_nxt  = S_ROUND;
        end
      end
      S_ROUND: begin
        ctrl.rnd = 1'b1;
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        ctrl.fold = 1'b1;
        if (!pad_r) begin
          bits_nxt  = bits_r + 64'd512;
          fill_nxt  = '0;
          state_nxt = fin_r ? S_FIN : S_IDLE;
        end else if (len_here_r) begin
          oidx_nxt  = '0;
          state_nxt = S_OUT;
        end else begin
          len_here_nxt = 1'b1;
          wptr_nxt     = '0;
          state_nxt    = S_PAD;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          oidx_nxt = oidx_r + 5'd1;
          if (oidx_r == 5'd31) begin
            ctrl.init = 1'b1;
            fill_nxt  = '0;
            bits_nxt  = '0;
            pad_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fill_r     <= '0;
      bits_r     <= '0;
      fin_r      <= 1'b0;
      pad_r      <= 1'b0;
      len_here_r <= 1'b0;
      first_r    <= 1'b0;
      wptr_r     <= '0;
      cnt_r      <= '0;
      rnd_r      <= '0;
      oidx_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      bits_r     <= bits_nxt;
      fin_r      <= fin_nxt;
      pad_r      <= pad_nxt;
      len_here_r <= len_here_nxt;
      first_r    <= first_nxt;
      wptr_r     <= wptr_nxt;
      cnt_r      <= cnt_nxt;
      rnd_r      <= rnd_nxt;
      oidx_r     <= oidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r <= total_nxt;
    gath_r  <= gath_nxt;
  end
endmodule

/* hw/rtl/sha_checker.sv */
// Port-level checks for the SHA-256 hasher, bound to the top level.
// Depends on sha256_message_digest_assert.svh.
`include "sha256_message_digest_assert.svh"

module sha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);
  // input is never taken while the digest is being emitted
  `SHA_ASSERT_NOW(a_no_overlap, in_tready, !out_tvalid)
  // tlast marks byte 31 and nothing else
  `SHA_ASSERT_NOW(a_last_idx, out_tvalid, out_tlast == (out_tdata[12:8] == 5'd31))
  // the digest run ends after its last item
  `SHA_ASSERT_NEXT(a_run_end, out_tvalid && out_tready && out_tlast, !out_tvalid)
  `SHA_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule

bind sha256_message_digest sha_checker u_sha_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);
